// ----- rtl/kic_pkg.sv -----
// Shared types, constants and the precedence helper function of the keypad infix calculator.
package kic_pkg;

    localparam int MAX_DIGITS_DEF    = 3;
    localparam int OPERAND_DEPTH_DEF = 4;
    localparam int OPR_DEPTH         = 2;

    localparam logic [4:0] NO_DIGIT   = 5'd16;
    localparam logic [3:0] KEY_NONE   = 4'd0;
    localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
    localparam logic [3:0] KEY_ADD    = 4'd10;
    localparam logic [3:0] KEY_CLEAR  = 4'd14;
    localparam logic [3:0] KEY_ASSIGN = 4'd15;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_SUB    = 3'd1;
    localparam logic [2:0] OP_MUL    = 3'd2;
    localparam logic [2:0] OP_DIV    = 3'd3;
    localparam logic [2:0] OP_ASSIGN = 3'd4;

    localparam logic [1:0] SHOW_KEEP  = 2'd0;
    localparam logic [1:0] SHOW_VALUE = 2'd1;
    localparam logic [1:0] SHOW_BLANK = 2'd2;

    localparam logic [1:0] SEL_ZERO  = 2'd0;
    localparam logic [1:0] SEL_ENTRY = 2'd1;
    localparam logic [1:0] SEL_TOP   = 2'd2;

    typedef struct packed {
        logic       latch_key;
        logic       nokey;
        logic       digit_take;
        logic       push_entry;
        logic       end_expr;
        logic       pop_opr;
        logic       pop_rhs;
        logic       pop_lhs;
        logic       alu_exec;
        logic       div_start;
        logic       div_take;
        logic       push_res;
        logic       push_opr;
        logic       res_load;
        logic [1:0] res_show;
        logic [1:0] res_sel;
        logic       res_done;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic key_valid;
        logic is_digit;
        logic digit_ok;
        logic op_new;
        logic is_clear;
        logic is_assign;
        logic is_div;
        logic reduce_ok;
        logic div_done;
    } sts_t;

    // Precedence: add/sub 1, mul/div 2, assign 0.
    function automatic logic [1:0] prec(input logic [2:0] op);
        logic [1:0] p;
        case (op)
            OP_ADD, OP_SUB: p = 2'd1;
            OP_MUL, OP_DIV: p = 2'd2;
            default:        p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

// ----- rtl/kic_if.sv -----
// Valid/ready channel interfaces for keypad scans and display results.
interface kic_key_if;
    logic       valid;
    logic       ready;
    logic       key_valid;
    logic [3:0] key_code;

    modport source (output valid, key_valid, key_code, input ready);
    modport sink   (input valid, key_valid, key_code, output ready);
endinterface

interface kic_res_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  show;
    logic signed [31:0] value;
    logic               done_res;
    logic               div_error;

    modport source (output valid, show, value, done_res, div_error, input ready);
    modport sink   (input valid, show, value, done_res, div_error, output ready);
endinterface

// ----- rtl/keypad_infix_calculator.sv -----
// Top level of the keypad infix calculator: controller plus datapath.
//
// Usage: each request on the keys channel carries one keypad scan
// (key_valid, key_code). Every scan yields exactly one request on the
// results channel with show, value, done_res and div_error. Digits build
// an entry of up to MAX_DIGITS digits; operators evaluate with precedence
// through an operand store of OPERAND_DEPTH entries and a two-entry
// operator store.
// Sequence: a no-key scan, a digit or clear goes from decode straight to
// the output register. An operator passes through a check and, for each
// reduction it triggers, pops the operator, the right and the left
// operand, executes and pushes the result; a division waits on a radix-2
// divider that settles one quotient bit per cycle. The operator store only
// ever holds an add or subtract under a multiply or divide, so a key
// triggers at most two reductions and one division.
// Throughput: one scan at a time; a new scan is accepted as soon as the
// previous one has moved into the output register, even if that result
// has not yet been taken.
// Reset clears the expression, the entry and the repeat filters. When the
// receiver stalls, the finished result holds in the output register and
// the next scan waits after its own evaluation until the register frees.
module keypad_infix_calculator
#(
    parameter int MAX_DIGITS    = kic_pkg::MAX_DIGITS_DEF,
    parameter int OPERAND_DEPTH = kic_pkg::OPERAND_DEPTH_DEF
)
(
    input logic   clk,
    input logic   rst_n,
    kic_key_if.sink   keys,
    kic_res_if.source results
);

    kic_pkg::cmd_t cmd;
    kic_pkg::sts_t sts;

    // The controller owns the handshakes and the sequencing.
    kic_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (keys.valid),
        .in_ready  (keys.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds every store and the payload registers.
    kic_dp
    #(
        .MAX_DIGITS    (MAX_DIGITS),
        .OPERAND_DEPTH (OPERAND_DEPTH)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_key_valid (keys.key_valid),
        .in_key_code  (keys.key_code),
        .cmd          (cmd),
        .sts          (sts),
        .show         (results.show),
        .value        (results.value),
        .done_res     (results.done_res),
        .div_error    (results.div_error)
    );

endmodule

// ----- rtl/kic_div.sv -----
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
module kic_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] quot,
    output logic        div_zero
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] q_reg;
    logic [31:0] mb_reg;
    logic        neg_reg;
    logic [31:0] quot_reg;
    logic        dz_reg;
    logic [32:0] trial;
    logic [32:0] diff;
    logic [31:0] q_step;
    logic [31:0] rem_step;

    always_comb
    begin
        trial = {rem_reg, q_reg[31]};
        diff  = trial - {1'b0, mb_reg};
        if (!diff[32])
        begin
            rem_step = diff[31:0];
            q_step   = {q_reg[30:0], 1'b1};
        end
        else
        begin
            rem_step = trial[31:0];
            q_step   = {q_reg[30:0], 1'b0};
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = (b != 32'd0);
            done_next = (b == 32'd0);
        end
        else if (busy_reg && cnt_reg == 5'd31)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            if (start)
                cnt_reg <= 5'd0;
            else if (busy_reg)
                cnt_reg <= cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= 32'd0;
            q_reg    <= a[31] ? (32'd0 - a) : a;
            mb_reg   <= b[31] ? (32'd0 - b) : b;
            neg_reg  <= a[31] ^ b[31];
            dz_reg   <= (b == 32'd0);
            quot_reg <= 32'd0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            q_reg   <= q_step;
            if (cnt_reg == 5'd31)
                quot_reg <= neg_reg ? (32'd0 - q_step) : q_step;
        end
    end

    assign done     = done_reg;
    assign quot     = quot_reg;
    assign div_zero = dz_reg;

endmodule

// ----- rtl/kic_dp.sv -----
// Datapath: key latch, entry builder, operand and operator stores, ALU and result registers.
module kic_dp
#(
    parameter int MAX_DIGITS    = kic_pkg::MAX_DIGITS_DEF,
    parameter int OPERAND_DEPTH = kic_pkg::OPERAND_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_key_valid,
    input  logic [3:0]          in_key_code,
    input  kic_pkg::cmd_t       cmd,
    output kic_pkg::sts_t       sts,
    output logic [1:0]          show,
    output logic signed [31:0]  value,
    output logic                done_res,
    output logic                div_error
);

    localparam int EW = $clog2(10 ** MAX_DIGITS);
    localparam int DW = $clog2(MAX_DIGITS + 1);
    localparam int CW = $clog2(OPERAND_DEPTH + 1);
    localparam int IW = $clog2(OPERAND_DEPTH);

    logic          key_valid_reg;
    logic [3:0]    key_code_reg;
    logic [EW-1:0] entry_reg;
    logic [EW-1:0] entry_next;
    logic [DW-1:0] digit_count_reg;
    logic [4:0]    last_digit_reg;
    logic [3:0]    last_op_reg;
    logic [31:0]   opd_mem [OPERAND_DEPTH];
    logic [CW-1:0] opd_count_reg;
    logic [CW-1:0] opd_cnt_m1;
    logic [31:0]   opd_top;
    logic [1:0]    opr_mem [kic_pkg::OPR_DEPTH];
    logic [1:0]    opr_count_reg;
    logic [1:0]    opr_cnt_m1;
    logic [1:0]    opr_top;
    logic [1:0]    cur_op_reg;
    logic [2:0]    key_op;
    logic [3:0]    key_off;
    logic [31:0]   rhs_reg;
    logic [31:0]   lhs_reg;
    logic [31:0]   alu_reg;
    logic          err_reg;
    logic          push_opd;
    logic [31:0]   push_val;
    logic [1:0]    res_show_reg;
    logic [31:0]   res_value_reg;
    logic          res_done_reg;
    logic [31:0]   res_value;
    logic [1:0]    out_show_reg;
    logic [31:0]   out_value_reg;
    logic          out_done_reg;
    logic          out_err_reg;
    logic          div_done;
    logic [31:0]   div_quot;
    logic          div_zero;

    kic_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .a        (lhs_reg),
        .b        (rhs_reg),
        .done     (div_done),
        .quot     (div_quot),
        .div_zero (div_zero)
    );

    assign entry_next = EW'(entry_reg * EW'(10)) + EW'(key_code_reg);
    assign opd_cnt_m1 = opd_count_reg - CW'(1);
    assign opd_top    = (opd_count_reg == '0) ? 32'd0 : opd_mem[opd_cnt_m1[IW-1:0]];
    assign opr_cnt_m1 = opr_count_reg - 2'd1;
    assign opr_top    = opr_mem[opr_cnt_m1[0]];
    assign key_off    = key_code_reg - kic_pkg::KEY_ADD;
    assign key_op     = (key_code_reg == kic_pkg::KEY_ASSIGN) ? kic_pkg::OP_ASSIGN
                                                              : {1'b0, key_off[1:0]};

    always_comb
    begin
        sts.key_valid = key_valid_reg;
        sts.is_digit  = (key_code_reg <= kic_pkg::KEY_LAST_DIGIT);
        sts.digit_ok  = (DW'(MAX_DIGITS) > digit_count_reg) &&
                        ({1'b0, key_code_reg} != last_digit_reg);
        sts.op_new    = (key_code_reg != last_op_reg);
        sts.is_clear  = (key_code_reg == kic_pkg::KEY_CLEAR);
        sts.is_assign = (key_code_reg == kic_pkg::KEY_ASSIGN);
        sts.is_div    = ({1'b0, cur_op_reg} == kic_pkg::OP_DIV);
        sts.reduce_ok = (opr_count_reg != 2'd0) &&
                        (kic_pkg::prec(key_op) <= kic_pkg::prec({1'b0, opr_top}));
        sts.div_done  = div_done;
    end

    // Operand pushes come from the entry or from a finished operation.
    assign push_opd = cmd.push_entry || cmd.push_res;
    assign push_val = cmd.push_res ? alu_reg : 32'(entry_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid_reg   <= 1'b0;
            key_code_reg    <= kic_pkg::KEY_NONE;
            entry_reg       <= '0;
            digit_count_reg <= '0;
            last_digit_reg  <= kic_pkg::NO_DIGIT;
            last_op_reg     <= kic_pkg::KEY_NONE;
            opd_count_reg   <= '0;
            opr_count_reg   <= 2'd0;
            err_reg         <= 1'b0;
        end
        else
        begin
            if (cmd.latch_key)
            begin
                key_valid_reg <= in_key_valid;
                key_code_reg  <= in_key_code;
                err_reg       <= 1'b0;
            end
            if (cmd.nokey)
                last_digit_reg <= kic_pkg::NO_DIGIT;
            if (cmd.digit_take)
            begin
                last_op_reg     <= kic_pkg::KEY_NONE;
                entry_reg       <= entry_next;
                digit_count_reg <= digit_count_reg + DW'(1);
                last_digit_reg  <= {1'b0, key_code_reg};
            end
            if (cmd.push_entry)
            begin
                last_digit_reg  <= kic_pkg::NO_DIGIT;
                digit_count_reg <= '0;
                entry_reg       <= '0;
                last_op_reg     <= key_code_reg;
            end
            if (push_opd && opd_count_reg < CW'(OPERAND_DEPTH))
                opd_count_reg <= opd_count_reg + CW'(1);
            if ((cmd.pop_rhs || cmd.pop_lhs) && opd_count_reg != '0)
                opd_count_reg <= opd_cnt_m1;
            if (cmd.pop_opr)
                opr_count_reg <= opr_cnt_m1;
            if (cmd.push_opr && opr_count_reg < 2'(kic_pkg::OPR_DEPTH))
                opr_count_reg <= opr_count_reg + 2'd1;
            if (cmd.div_take && div_zero)
                err_reg <= 1'b1;
            if (cmd.end_expr)
            begin
                opd_count_reg   <= '0;
                opr_count_reg   <= 2'd0;
                entry_reg       <= '0;
                digit_count_reg <= '0;
                last_digit_reg  <= kic_pkg::NO_DIGIT;
            end
        end
    end

    always_comb
    begin
        case (cmd.res_sel)
            kic_pkg::SEL_ENTRY: res_value = 32'(entry_next);
            kic_pkg::SEL_TOP:   res_value = opd_top;
            default:            res_value = 32'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push_opd && opd_count_reg < CW'(OPERAND_DEPTH))
            opd_mem[opd_count_reg[IW-1:0]] <= push_val;
        if (cmd.push_opr && opr_count_reg < 2'(kic_pkg::OPR_DEPTH))
            opr_mem[opr_count_reg[0]] <= key_op[1:0];
        if (cmd.pop_opr)
            cur_op_reg <= opr_top;
        if (cmd.pop_rhs)
            rhs_reg <= opd_top;
        if (cmd.pop_lhs)
            lhs_reg <= opd_top;
        if (cmd.alu_exec)
        begin
            case ({1'b0, cur_op_reg})
                kic_pkg::OP_ADD: alu_reg <= lhs_reg + rhs_reg;
                kic_pkg::OP_SUB: alu_reg <= lhs_reg - rhs_reg;
                kic_pkg::OP_MUL: alu_reg <= 32'(lhs_reg * rhs_reg);
                default:         alu_reg <= 32'd0;
            endcase
        end
        if (cmd.div_take)
            alu_reg <= div_quot;
        if (cmd.res_load)
        begin
            res_show_reg  <= cmd.res_show;
            res_value_reg <= (cmd.res_show == kic_pkg::SHOW_VALUE) ? res_value : 32'd0;
            res_done_reg  <= cmd.res_done;
        end
        if (cmd.out_load)
        begin
            out_show_reg  <= res_show_reg;
            out_value_reg <= res_value_reg;
            out_done_reg  <= res_done_reg;
            out_err_reg   <= err_reg;
        end
    end

    assign show      = out_show_reg;
    assign value     = out_value_reg;
    assign done_res  = out_done_reg;
    assign div_error = out_err_reg;

    a_opd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        opd_count_reg <= CW'(OPERAND_DEPTH))
        else $error("operand count beyond store depth");
    a_opr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        opr_count_reg <= 2'(kic_pkg::OPR_DEPTH))
        else $error("operator count beyond store depth");

endmodule

// ----- rtl/kic_ctrl.sv -----
// Controller state machine that sequences decode, reductions and result delivery.
module kic_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  kic_pkg::sts_t sts,
    output kic_pkg::cmd_t cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_CHECK    = 4'd2;
    localparam logic [3:0] S_POP_RHS  = 4'd3;
    localparam logic [3:0] S_POP_LHS  = 4'd4;
    localparam logic [3:0] S_EXEC     = 4'd5;
    localparam logic [3:0] S_DIV_WAIT = 4'd6;
    localparam logic [3:0] S_PUSH     = 4'd7;
    localparam logic [3:0] S_OUT      = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.latch_key = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.res_load = 1'b1;
                cmd.res_show = kic_pkg::SHOW_KEEP;
                cmd.res_sel  = kic_pkg::SEL_ZERO;
                state_next   = S_OUT;
                if (!sts.key_valid)
                    cmd.nokey = 1'b1;
                else if (sts.is_digit)
                begin
                    if (sts.digit_ok)
                    begin
                        cmd.digit_take = 1'b1;
                        cmd.res_show   = kic_pkg::SHOW_VALUE;
                        cmd.res_sel    = kic_pkg::SEL_ENTRY;
                    end
                end
                else if (sts.op_new)
                begin
                    cmd.push_entry = 1'b1;
                    if (sts.is_clear)
                    begin
                        cmd.end_expr = 1'b1;
                        cmd.res_show = kic_pkg::SHOW_VALUE;
                        cmd.res_done = 1'b1;
                    end
                    else
                    begin
                        cmd.res_load = 1'b0;
                        state_next   = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (sts.reduce_ok)
                begin
                    cmd.pop_opr = 1'b1;
                    state_next  = S_POP_RHS;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_OUT;
                    if (sts.is_assign)
                    begin
                        cmd.end_expr = 1'b1;
                        cmd.res_show = kic_pkg::SHOW_VALUE;
                        cmd.res_sel  = kic_pkg::SEL_TOP;
                        cmd.res_done = 1'b1;
                    end
                    else
                    begin
                        cmd.push_opr = 1'b1;
                        cmd.res_show = kic_pkg::SHOW_BLANK;
                    end
                end
            end
            S_POP_RHS:
            begin
                cmd.pop_rhs = 1'b1;
                state_next  = S_POP_LHS;
            end
            S_POP_LHS:
            begin
                cmd.pop_lhs = 1'b1;
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.alu_exec  = 1'b1;
                cmd.div_start = sts.is_div;
                state_next    = sts.is_div ? S_DIV_WAIT : S_PUSH;
            end
            S_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.div_take = 1'b1;
                    state_next   = S_PUSH;
                end
            end
            S_PUSH:
            begin
                cmd.push_res = 1'b1;
                state_next   = S_CHECK;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("second request taken while an item is in work");
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> state_reg == S_DIV_WAIT)
        else $error("divide started without waiting for it");
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result loaded but not presented");

endmodule
